[hdl/stt_pkg.sv]
// shared constants, codes and types of the subtitle time table lookup core
package stt_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam int TIME_W = 32;
   localparam int QUERY_W = 40;
   localparam int OUT_IDX_W = 10;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [2:0] STATUS_MATCH = 3'd0;
   localparam logic [2:0] STATUS_NO_MATCH = 3'd1;
   localparam logic [2:0] STATUS_APPENDED = 3'd2;
   localparam logic [2:0] STATUS_FULL = 3'd3;
   localparam logic [2:0] STATUS_CLEARED = 3'd4;

   localparam logic CSR_DISPLAY_SPAN = 1'b0;
   localparam logic CSR_TIME_SHIFT = 1'b1;

   localparam logic [TIME_W-1:0] MAX_DISPLAY_RESET = 32'd5000;
   localparam logic [TIME_W-1:0] SENTINEL_START = 32'hf000_0000;
   localparam logic [TIME_W-1:0] SENTINEL_STOP = 32'hf000_0001;

   typedef struct packed {
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] stop;
   } entry_type;

   typedef struct packed {
      logic hit;
      logic past;
   } cmp_result_type;

endpackage

[hdl/subtitle_time_table_lookup_core.sv]
// top level: control registers and the table sequencer
// A beat is taken on a clock edge where start is high and busy is low; its result comes
// back on the rsp_ ports for one cycle, marked by rsp_strobe, the cycle after the work ends,
// and cannot be held off. Clear, a dropped append, an append into an empty table, a lookup
// of an empty table and the unused op code finish in the accept cycle and leave busy low.
// Any other append holds busy for one cycle, as the entry ram takes one write per cycle and
// the previous entry's stop is written first. A lookup holds busy while it compares entries,
// up to TABLE_DEPTH of them, since entries come out of the single ram read port
// one per cycle. The csr_ registers may be written only while busy is low and no result is
// still due; there is no clearing pass after reset.
module subtitle_time_table_lookup_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_op,
   input  logic [stt_pkg::TIME_W-1:0]    req_entry_start,
   input  logic [stt_pkg::QUERY_W-1:0]   req_query_time,
   output logic                          rsp_strobe,
   output logic [2:0]                    rsp_status,
   output logic [stt_pkg::OUT_IDX_W-1:0] rsp_entry_index,
   output logic [stt_pkg::TIME_W-1:0]    rsp_match_start,
   output logic [stt_pkg::TIME_W-1:0]    rsp_match_stop,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [stt_pkg::TIME_W-1:0]    csr_write_data
);

   logic [stt_pkg::TIME_W-1:0]        display_span_ff;
   logic signed [stt_pkg::TIME_W-1:0] time_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         display_span_ff <= stt_pkg::MAX_DISPLAY_RESET;
         time_shift_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            stt_pkg::CSR_DISPLAY_SPAN: display_span_ff <= csr_write_data;
            stt_pkg::CSR_TIME_SHIFT:   time_shift_ff <= $signed(csr_write_data);
            default: ;
         endcase
      end
   end

   stt_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_entry_start  (req_entry_start),
      .req_query_time   (req_query_time),
      .display_span     (display_span_ff),
      .time_shift       (time_shift_ff),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_match_start  (rsp_match_start),
      .rsp_match_stop   (rsp_match_stop)
   );

endmodule

[hdl/stt_ram.sv]
// simple dual port ram, one write and one registered read per cycle
module stt_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/stt_cmp.sv]
// shifted interval compare of one table entry against the query time
module stt_cmp (
   input  stt_pkg::entry_type              entry,
   input  logic signed [stt_pkg::TIME_W-1:0] time_shift,
   input  logic [stt_pkg::QUERY_W-1:0]     query_time,
   output stt_pkg::cmp_result_type         result
);

   localparam int EXT_W = stt_pkg::QUERY_W + 2;

   logic signed [EXT_W-1:0] shift_ext;
   logic signed [EXT_W-1:0] head;
   logic signed [EXT_W-1:0] tail;
   logic signed [EXT_W-1:0] query;

   always_comb begin
      shift_ext = EXT_W'(time_shift);
      head = $signed({(EXT_W - stt_pkg::TIME_W)'(0), entry.start}) + shift_ext;
      tail = $signed({(EXT_W - stt_pkg::TIME_W)'(0), entry.stop}) + shift_ext;
      query = $signed({2'b00, query_time});
      result.hit = (head <= query) && (tail > query);
      result.past = head > query;
   end

endmodule

[hdl/stt_seq.sv]
// op sequencer: append writes, clear, and the in-order lookup scan over the entry ram
module stt_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_op,
   input  logic [stt_pkg::TIME_W-1:0]          req_entry_start,
   input  logic [stt_pkg::QUERY_W-1:0]         req_query_time,
   input  logic [stt_pkg::TIME_W-1:0]          display_span,
   input  logic signed [stt_pkg::TIME_W-1:0]   time_shift,
   output logic                                rsp_strobe,
   output logic [2:0]                          rsp_status,
   output logic [stt_pkg::OUT_IDX_W-1:0]       rsp_entry_index,
   output logic [stt_pkg::TIME_W-1:0]          rsp_match_start,
   output logic [stt_pkg::TIME_W-1:0]          rsp_match_stop
);

   localparam int IDX_W = stt_pkg::IDX_W;
   localparam int CNT_W = stt_pkg::CNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPEND,
      ST_SCAN
   } state_type;

   state_type                     state_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [stt_pkg::TIME_W-1:0]    last_start_ff;
   logic [stt_pkg::TIME_W-1:0]    start_ff;
   logic [stt_pkg::QUERY_W-1:0]   query_ff;
   logic [IDX_W-1:0]              data_idx_ff;
   logic                          rsp_strobe_ff;
   logic [2:0]                    rsp_status_ff;
   logic [stt_pkg::OUT_IDX_W-1:0] rsp_entry_index_ff;
   logic [stt_pkg::TIME_W-1:0]    rsp_match_start_ff;
   logic [stt_pkg::TIME_W-1:0]    rsp_match_stop_ff;

   logic                          accept;
   logic                          table_empty;
   logic                          table_full;
   logic                          scan_last;
   logic [IDX_W-1:0]              prev_idx;
   logic [stt_pkg::TIME_W-1:0]    prev_sum;
   logic [stt_pkg::TIME_W-1:0]    prev_stop;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   stt_pkg::entry_type            wr_data;
   logic [IDX_W-1:0]              rd_addr;
   stt_pkg::entry_type            rd_data;
   stt_pkg::cmp_result_type       cmp;

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);
   assign table_empty = (count_ff == '0);
   assign table_full = (count_ff == CNT_W'(stt_pkg::TABLE_DEPTH));
   assign scan_last = ((CNT_W'(data_idx_ff) + CNT_W'(1)) == count_ff);
   assign prev_idx = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      prev_sum = last_start_ff + display_span;
      if (prev_sum >= req_entry_start) begin
         prev_stop = req_entry_start - 32'd1;
      end else begin
         prev_stop = prev_sum;
      end
   end

   // write path: previous entry fixup at accept, new entry in the next cycle; a first entry at accept
   always_comb begin
      wr_en = 1'b0;
      wr_addr = prev_idx;
      wr_data.start = last_start_ff;
      wr_data.stop = prev_stop;
      if (accept && (req_op == stt_pkg::OP_APPEND) && !table_full) begin
         wr_en = 1'b1;
         if (table_empty) begin
            wr_addr = '0;
            wr_data.start = req_entry_start;
            wr_data.stop = req_entry_start + display_span;
         end else if ((prev_idx != '0) && (last_start_ff == '0)) begin
            wr_data.start = stt_pkg::SENTINEL_START;
            wr_data.stop = stt_pkg::SENTINEL_STOP;
         end
      end else if (state_ff == ST_APPEND) begin
         wr_en = 1'b1;
         wr_addr = IDX_W'(count_ff);
         wr_data.start = start_ff;
         wr_data.stop = start_ff + display_span;
      end
   end

   // read one entry ahead of the one being compared
   assign rd_addr = (state_ff == ST_SCAN) ? (data_idx_ff + IDX_W'(1)) : '0;

   stt_ram #(
      .DEPTH (stt_pkg::TABLE_DEPTH),
      .WIDTH ($bits(stt_pkg::entry_type))
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stt_cmp u_cmp (
      .entry      (rd_data),
      .time_shift (time_shift),
      .query_time (query_ff),
      .result     (cmp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         rsp_entry_index_ff <= '0;
         rsp_match_start_ff <= '0;
         rsp_match_stop_ff <= '0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_op)
                     stt_pkg::OP_CLEAR: begin
                        count_ff <= '0;
                        rsp_strobe_ff <= 1'b1;
                        rsp_status_ff <= stt_pkg::STATUS_CLEARED;
                     end
                     stt_pkg::OP_APPEND: begin
                        if (table_full) begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_status_ff <= stt_pkg::STATUS_FULL;
                        end else if (table_empty) begin
                           last_start_ff <= req_entry_start;
                           count_ff <= CNT_W'(1);
                           rsp_strobe_ff <= 1'b1;
                           rsp_status_ff <= stt_pkg::STATUS_APPENDED;
                        end else begin
                           start_ff <= req_entry_start;
                           state_ff <= ST_APPEND;
                        end
                     end
                     stt_pkg::OP_LOOKUP: begin
                        if (table_empty) begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_status_ff <= stt_pkg::STATUS_NO_MATCH;
                        end else begin
                           query_ff <= req_query_time;
                           data_idx_ff <= '0;
                           state_ff <= ST_SCAN;
                        end
                     end
                     default: begin
                        rsp_strobe_ff <= 1'b1;
                        rsp_status_ff <= stt_pkg::STATUS_NO_MATCH;
                     end
                  endcase
               end
            end
            ST_APPEND: begin
               last_start_ff <= start_ff;
               count_ff <= count_ff + CNT_W'(1);
               rsp_strobe_ff <= 1'b1;
               rsp_status_ff <= stt_pkg::STATUS_APPENDED;
               rsp_entry_index_ff <= stt_pkg::OUT_IDX_W'(count_ff);
               state_ff <= ST_IDLE;
            end
            ST_SCAN: begin
               priority if (cmp.hit) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_status_ff <= stt_pkg::STATUS_MATCH;
                  rsp_entry_index_ff <= stt_pkg::OUT_IDX_W'(data_idx_ff);
                  rsp_match_start_ff <= rd_data.start;
                  rsp_match_stop_ff <= rd_data.stop;
                  state_ff <= ST_IDLE;
               end else if (cmp.past || scan_last) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_status_ff <= stt_pkg::STATUS_NO_MATCH;
                  state_ff <= ST_IDLE;
               end else begin
                  data_idx_ff <= data_idx_ff + IDX_W'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry_index = rsp_entry_index_ff;
   assign rsp_match_start = rsp_match_start_ff;
   assign rsp_match_stop = rsp_match_stop_ff;

endmodule
